// ----- design/fspe_pkg.sv -----
// Package for the sync-framed packet encoder.
// Holds the opcode and register index codes, step numbers and shared types.
// Used by every module of the block; depends on nothing.
package fspe_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned AddrW = 48;
  localparam int unsigned StepW = 4;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [ByteW-1:0] MaxPayload = 8'd245;

  localparam logic [1:0] OP_INIT   = 2'd0;
  localparam logic [1:0] OP_RX     = 2'd1;
  localparam logic [1:0] OP_STATUS = 2'd2;
  localparam logic [1:0] OP_DATA   = 2'd3;

  localparam logic [CfgIdxW-1:0] CFG_SYNC        = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_VERSION     = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_TYPE_INIT   = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_TYPE_RX     = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_TYPE_STATUS = 3'd4;

  localparam logic [StepW-1:0] STEP_SYNC    = 4'd0;
  localparam logic [StepW-1:0] STEP_VERSION = 4'd1;
  localparam logic [StepW-1:0] STEP_TYPE    = 4'd2;
  localparam logic [StepW-1:0] STEP_ADDR5   = 4'd3;
  localparam logic [StepW-1:0] STEP_ADDR4   = 4'd4;
  localparam logic [StepW-1:0] STEP_ADDR3   = 4'd5;
  localparam logic [StepW-1:0] STEP_ADDR2   = 4'd6;
  localparam logic [StepW-1:0] STEP_ADDR1   = 4'd7;
  localparam logic [StepW-1:0] STEP_ADDR0   = 4'd8;
  localparam logic [StepW-1:0] STEP_FIELD   = 4'd9;
  localparam logic [StepW-1:0] STEP_LEN     = 4'd10;
  localparam logic [StepW-1:0] STEP_MAX     = 4'd11;

  typedef enum logic [2:0] {
    CMD_INIT,
    CMD_RX,
    CMD_STATUS,
    CMD_DATA,
    CMD_LAST
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e          kind;
    logic [AddrW-1:0]   addr;
    logic [ByteW-1:0]   aux;
    logic [ByteW-1:0]   len;
  } cmd_t;

  typedef struct packed {
    logic [ByteW-1:0] sync;
    logic [ByteW-1:0] version;
    logic [ByteW-1:0] type_init;
    logic [ByteW-1:0] type_rx;
    logic [ByteW-1:0] type_status;
  } cfg_regs_t;

  typedef struct packed {
    logic             busy;
    logic [StepW-1:0] step;
  } bk_status_t;

endpackage

// ----- design/fspe_front.sv -----
// Front end of the packet encoder: accepts input beats and turns them into commands.
// Tracks the open receive frame so stray payload beats are dropped here.
// Depends on fspe_pkg.
module fspe_front
  import fspe_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [1:0]              opcode_i,
  input  logic [AddrW-1:0]        peer_address_i,
  input  logic signed [ByteW-1:0] signal_strength_i,
  input  logic [ByteW-1:0]        payload_len_i,
  input  logic [ByteW-1:0]        status_code_i,
  input  logic [ByteW-1:0]        data_byte_i,
  input  logic                    q_ready_i,
  output logic                    q_push_o,
  output cmd_t                    q_cmd_o
);

  logic [ByteW-1:0] left_q, left_d;
  logic             accept;
  logic             push;
  logic [ByteW-1:0] sat_len;

  assign in_ready_o = q_ready_i;
  assign accept     = in_valid_i && q_ready_i;
  assign sat_len    = (payload_len_i > MaxPayload) ? MaxPayload : payload_len_i;

  always_comb begin
    push          = 1'b1;
    left_d        = '0;
    q_cmd_o.kind  = CMD_INIT;
    q_cmd_o.addr  = peer_address_i;
    q_cmd_o.aux   = data_byte_i;
    q_cmd_o.len   = sat_len;
    unique case (opcode_i)
      OP_INIT: begin
        q_cmd_o.kind = CMD_INIT;
      end
      OP_RX: begin
        q_cmd_o.kind = CMD_RX;
        q_cmd_o.aux  = $unsigned(signal_strength_i);
        left_d       = sat_len;
      end
      OP_STATUS: begin
        q_cmd_o.kind = CMD_STATUS;
        q_cmd_o.aux  = status_code_i;
      end
      OP_DATA: begin
        push         = (left_q != '0);
        q_cmd_o.kind = (left_q == 8'd1) ? CMD_LAST : CMD_DATA;
        left_d       = (left_q != '0) ? left_q - 8'd1 : left_q;
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  assign q_push_o = accept && push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q <= '0;
    end else if (accept) begin
      left_q <= left_d;
    end
  end

endmodule

// ----- design/fspe_fifo.sv -----
// Short command queue between the front end and the byte sequencer.
// Register array with head and tail pointers and a fill count.
// Depends on fspe_pkg.
module fspe_fifo
  import fspe_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t data_i,
  output logic ready_o,
  output logic valid_o,
  output cmd_t data_o,
  input  logic pop_i
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

  cmd_t            mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign ready_o = (count_q != CntFull);
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// ----- design/fspe_back.sv -----
// Byte sequencer of the packet encoder: walks each command through its frame bytes.
// Keeps the running XOR checksum and drives the registered output beat.
// Depends on fspe_pkg.
module fspe_back
  import fspe_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_regs_t        cfg_i,
  input  logic             q_valid_i,
  input  cmd_t             q_cmd_i,
  output logic             q_pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [ByteW-1:0] out_byte_o,
  output logic             frame_end_o,
  output bk_status_t       status_o
);

  logic             busy_q, busy_d;
  logic [StepW-1:0] step_q, step_d;
  cmd_t             cur_q, cur_d;
  logic [ByteW-1:0] xor_q, xor_d;
  logic             out_valid_q, out_valid_d;
  logic [ByteW-1:0] out_byte_q, out_byte_d;
  logic             out_end_q, out_end_d;

  cmd_t             act;
  logic [StepW-1:0] step;
  logic             load_en;
  logic             emit;
  logic [ByteW-1:0] cur_byte;
  logic             is_csum;
  logic             is_last;
  logic             clear_xor;
  logic [ByteW-1:0] type_byte;
  logic [ByteW-1:0] addr_byte;

  assign load_en = !out_valid_q || out_ready_i;
  assign act     = busy_q ? cur_q : q_cmd_i;
  assign step    = busy_q ? step_q : STEP_SYNC;
  assign emit    = load_en && (busy_q || q_valid_i);
  assign q_pop_o = load_en && !busy_q && q_valid_i;

  always_comb begin
    type_byte = cfg_i.type_init;
    unique case (act.kind)
      CMD_RX:     type_byte = cfg_i.type_rx;
      CMD_STATUS: type_byte = cfg_i.type_status;
      default:    type_byte = cfg_i.type_init;
    endcase
  end

  always_comb begin
    case (step)
      STEP_ADDR5: addr_byte = act.addr[47:40];
      STEP_ADDR4: addr_byte = act.addr[39:32];
      STEP_ADDR3: addr_byte = act.addr[31:24];
      STEP_ADDR2: addr_byte = act.addr[23:16];
      STEP_ADDR1: addr_byte = act.addr[15:8];
      default:    addr_byte = act.addr[7:0];
    endcase
  end

  always_comb begin
    cur_byte  = act.aux;
    is_csum   = 1'b0;
    is_last   = 1'b0;
    clear_xor = 1'b0;
    unique case (act.kind)
      CMD_DATA: begin
        is_last = 1'b1;
      end
      CMD_LAST: begin
        if (step != STEP_SYNC) begin
          is_csum = 1'b1;
          is_last = 1'b1;
        end
      end
      default: begin
        if (step == STEP_SYNC) begin
          cur_byte  = cfg_i.sync;
          clear_xor = 1'b1;
        end else if (step == STEP_VERSION) begin
          cur_byte = cfg_i.version;
        end else if (step == STEP_TYPE) begin
          cur_byte = type_byte;
        end else if (step <= STEP_ADDR0) begin
          cur_byte = addr_byte;
        end else if (act.kind == CMD_INIT) begin
          is_csum = 1'b1;
          is_last = 1'b1;
        end else if (act.kind == CMD_STATUS) begin
          if (step == STEP_FIELD) begin
            cur_byte = act.aux;
          end else begin
            is_csum = 1'b1;
            is_last = 1'b1;
          end
        end else begin
          if (step == STEP_FIELD) begin
            cur_byte = act.aux;
          end else if (step == STEP_LEN) begin
            cur_byte = act.len;
            is_last  = (act.len != '0);
          end else begin
            is_csum = 1'b1;
            is_last = 1'b1;
          end
        end
      end
    endcase
    if (is_csum) begin
      cur_byte = xor_q;
    end
  end

  always_comb begin
    busy_d      = busy_q;
    step_d      = step_q;
    cur_d       = cur_q;
    xor_d       = xor_q;
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    out_end_d   = out_end_q;
    if (emit) begin
      busy_d      = !is_last;
      step_d      = step + 1'b1;
      cur_d       = act;
      out_valid_d = 1'b1;
      out_byte_d  = cur_byte;
      out_end_d   = is_csum;
      if (clear_xor) begin
        xor_d = '0;
      end else if (!is_csum) begin
        xor_d = xor_q ^ cur_byte;
      end
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      step_q      <= '0;
      xor_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      step_q      <= step_d;
      xor_q       <= xor_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    out_byte_q <= out_byte_d;
    out_end_q  <= out_end_d;
  end

  assign out_valid_o     = out_valid_q;
  assign out_byte_o      = out_byte_q;
  assign frame_end_o     = out_end_q;
  assign status_o.busy   = busy_q;
  assign status_o.step   = step_q;

endmodule

// ----- design/sync_framed_packet_encoder_unit.sv -----
// Sync-framed packet encoder: frames with sync, header, payload and XOR checksum.
// An item's bytes pass through the command queue and the sequencer's registered output beat.
// Throughput: one payload beat per cycle while the queue and output are not stalled; a start beat
// keeps the byte sequencer busy while the command queue takes up to FIFO_DEPTH more beats.
// Reset clears queue, sequencer and frame state and loads the register defaults.
// Depends on fspe_pkg, fspe_front, fspe_fifo and fspe_back.
module sync_framed_packet_encoder_unit
  import fspe_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH = 4
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CfgIdxW-1:0]      cfg_index_i,
  input  logic [ByteW-1:0]        cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [1:0]              opcode_i,
  input  logic [AddrW-1:0]        peer_address_i,
  input  logic signed [ByteW-1:0] signal_strength_i,
  input  logic [ByteW-1:0]        payload_len_i,
  input  logic [ByteW-1:0]        status_code_i,
  input  logic [ByteW-1:0]        data_byte_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [ByteW-1:0]        out_byte_o,
  output logic                    frame_end_o
);

  cfg_regs_t  cfg_q;
  logic       q_push, q_ready, q_valid, q_pop;
  cmd_t       q_in_cmd, q_out_cmd;
  bk_status_t bk_status;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sync        <= 8'd170;
      cfg_q.version     <= 8'd1;
      cfg_q.type_init   <= 8'd1;
      cfg_q.type_rx     <= 8'd2;
      cfg_q.type_status <= 8'd3;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_SYNC:        cfg_q.sync        <= cfg_data_i;
        CFG_VERSION:     cfg_q.version     <= cfg_data_i;
        CFG_TYPE_INIT:   cfg_q.type_init   <= cfg_data_i;
        CFG_TYPE_RX:     cfg_q.type_rx     <= cfg_data_i;
        CFG_TYPE_STATUS: cfg_q.type_status <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  fspe_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .opcode_i          (opcode_i),
    .peer_address_i    (peer_address_i),
    .signal_strength_i (signal_strength_i),
    .payload_len_i     (payload_len_i),
    .status_code_i     (status_code_i),
    .data_byte_i       (data_byte_i),
    .q_ready_i         (q_ready),
    .q_push_o          (q_push),
    .q_cmd_o           (q_in_cmd)
  );

  fspe_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_in_cmd),
    .ready_o (q_ready),
    .valid_o (q_valid),
    .data_o  (q_out_cmd),
    .pop_i   (q_pop)
  );

  fspe_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_cmd_i     (q_out_cmd),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .frame_end_o (frame_end_o),
    .status_o    (bk_status)
  );

  a_pop_needs_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("Command queue popped while empty.");

  a_busy_step_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bk_status.busy |-> (bk_status.step != STEP_SYNC))
    else $error("Sequencer busy at the sync step.");

  a_busy_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bk_status.busy |-> (bk_status.step <= STEP_MAX))
    else $error("Sequencer step ran past the longest frame.");

  a_pop_drains_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |=> out_valid_o)
    else $error("Popped command produced no output beat.");

endmodule

// ----- tb/fspe_frame_monitor.sv -----
// Frame stream monitor for the sync-framed packet encoder testbench.
// Watches the register, item and byte channels, predicts every frame byte and compares.
// Depends on fspe_pkg; the testbench top reads its failure and pending counts.
module fspe_frame_monitor
  import fspe_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [ByteW-1:0]   cfg_data_i,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [1:0]         opcode_i,
  input  logic [AddrW-1:0]   peer_address_i,
  input  logic [ByteW-1:0]   signal_strength_i,
  input  logic [ByteW-1:0]   payload_len_i,
  input  logic [ByteW-1:0]   status_code_i,
  input  logic [ByteW-1:0]   data_byte_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic [ByteW-1:0]   out_byte_i,
  input  logic               frame_end_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  typedef struct packed {
    logic [ByteW-1:0] octet;
    logic             ends_frame;
  } frame_octet_t;

  frame_octet_t     frame_bytes_q[$];
  cfg_regs_t        regs;
  logic [ByteW-1:0] frame_xor;
  logic [ByteW-1:0] payload_left;
  logic             rx_open;

  task automatic report_mismatch(input string msg);
    if (fail_count_o < 100) begin
      $display("mismatch at %0t: %s", $time, msg);
    end
    fail_count_o++;
  endtask

  task automatic push_octet(input logic [ByteW-1:0] v, input bit fold, input bit ends);
    frame_octet_t e;
    e.octet = v;
    e.ends_frame = ends;
    frame_bytes_q.push_back(e);
    if (fold) begin
      frame_xor = frame_xor ^ v;
    end
  endtask

  task automatic push_header(input logic [ByteW-1:0] kind_byte, input logic [AddrW-1:0] addr);
    rx_open = 1'b0;
    payload_left = '0;
    frame_xor = '0;
    push_octet(regs.sync, 1'b0, 1'b0);
    push_octet(regs.version, 1'b1, 1'b0);
    push_octet(kind_byte, 1'b1, 1'b0);
    for (int i = 5; i >= 0; i--) begin
      push_octet(addr[i*8 +: 8], 1'b1, 1'b0);
    end
  endtask

  task automatic close_frame();
    push_octet(frame_xor, 1'b0, 1'b1);
    rx_open = 1'b0;
    payload_left = '0;
  endtask

  task automatic predict_frame_bytes();
    logic [ByteW-1:0] clipped;
    case (opcode_i)
      OP_INIT: begin
        push_header(regs.type_init, peer_address_i);
        close_frame();
      end
      OP_RX: begin
        clipped = (payload_len_i > MaxPayload) ? MaxPayload : payload_len_i;
        push_header(regs.type_rx, peer_address_i);
        push_octet(signal_strength_i, 1'b1, 1'b0);
        push_octet(clipped, 1'b1, 1'b0);
        if (clipped == '0) begin
          close_frame();
        end else begin
          rx_open = 1'b1;
          payload_left = clipped;
        end
      end
      OP_STATUS: begin
        push_header(regs.type_status, peer_address_i);
        push_octet(status_code_i, 1'b1, 1'b0);
        close_frame();
      end
      default: begin
        if (rx_open && payload_left != '0) begin
          push_octet(data_byte_i, 1'b1, 1'b0);
          payload_left = payload_left - 1'b1;
          if (payload_left == '0) begin
            close_frame();
          end
        end
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    frame_octet_t head;
    if (!rst_ni) begin
      regs = '{sync: 8'd170, version: 8'd1, type_init: 8'd1, type_rx: 8'd2,
               type_status: 8'd3};
      frame_xor = '0;
      payload_left = '0;
      rx_open = 1'b0;
      frame_bytes_q.delete();
      pending_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (frame_bytes_q.size() == 0) begin
          report_mismatch($sformatf("unexpected beat %02h end %0b", out_byte_i, frame_end_i));
        end else begin
          head = frame_bytes_q.pop_front();
          if (out_byte_i !== head.octet) begin
            report_mismatch($sformatf("out_byte %02h, want %02h", out_byte_i, head.octet));
          end
          if (frame_end_i !== head.ends_frame) begin
            report_mismatch($sformatf("frame_end %0b, want %0b", frame_end_i,
                                      head.ends_frame));
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_SYNC:        regs.sync = cfg_data_i;
          CFG_VERSION:     regs.version = cfg_data_i;
          CFG_TYPE_INIT:   regs.type_init = cfg_data_i;
          CFG_TYPE_RX:     regs.type_rx = cfg_data_i;
          CFG_TYPE_STATUS: regs.type_status = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        predict_frame_bytes();
      end
      pending_o <= frame_bytes_q.size();
    end
  end

endmodule

// ----- tb/tb.sv -----
// Testbench top for the sync-framed packet encoder: clock, reset, stimulus and verdict.
// Drives directed and random items and register writes under random stalls.
// Depends on fspe_pkg, sync_framed_packet_encoder_unit and fspe_frame_monitor.
module tb
  import fspe_pkg::*;
();

  localparam int HoldCycles = 300;
  localparam int HoldAfter = 6;
  localparam int SettleCycles = 40;
  localparam int StallLimit = 2000;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    cfg_valid_i = 1'b0;
  logic                    cfg_ready_o;
  logic [CfgIdxW-1:0]      cfg_index_i = '0;
  logic [ByteW-1:0]        cfg_data_i = '0;
  logic                    in_valid_i = 1'b0;
  logic                    in_ready_o;
  logic [1:0]              opcode_i = OP_INIT;
  logic [AddrW-1:0]        peer_address_i = '0;
  logic signed [ByteW-1:0] signal_strength_i = '0;
  logic [ByteW-1:0]        payload_len_i = '0;
  logic [ByteW-1:0]        status_code_i = '0;
  logic [ByteW-1:0]        data_byte_i = '0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic [ByteW-1:0]        out_byte_o;
  logic                    frame_end_o;

  int   fail_count;
  int   bytes_pending;
  int   send_idle_pct = 37;
  int   recv_idle_pct = 46;
  int   live_items = 0;
  int   stall_cycles = 0;
  logic hold_req = 1'b0;

  sync_framed_packet_encoder_unit dut (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .opcode_i, .peer_address_i, .signal_strength_i,
    .payload_len_i, .status_code_i, .data_byte_i,
    .out_valid_o, .out_ready_i, .out_byte_o, .frame_end_o
  );

  fspe_frame_monitor stream_mon (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_i(in_ready_o), .opcode_i, .peer_address_i,
    .signal_strength_i, .payload_len_i, .status_code_i, .data_byte_i,
    .out_valid_i(out_valid_o), .out_ready_i, .out_byte_i(out_byte_o),
    .frame_end_i(frame_end_o), .fail_count_o(fail_count), .pending_o(bytes_pending)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("tb NOT OK");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : byte_sink
    bit hold_taken;
    hold_taken = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  function automatic logic [ByteW-1:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [AddrW-1:0] rand_addr();
    logic [AddrW-1:0] a;
    a[47:32] = 16'($urandom_range(0, 65535));
    a[31:0] = $urandom();
    return a;
  endfunction

  task automatic send_item(input logic [1:0] op, input logic [AddrW-1:0] addr,
                           input logic [ByteW-1:0] rssi, input logic [ByteW-1:0] len,
                           input logic [ByteW-1:0] status, input logic [ByteW-1:0] data,
                           input bit live);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i <= op;
    peer_address_i <= addr;
    signal_strength_i <= rssi;
    payload_len_i <= len;
    status_code_i <= status;
    data_byte_i <= data;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (live) begin
      live_items++;
    end
  endtask

  task automatic send_payload(input bit live);
    send_item(OP_DATA, rand_addr(), rand_byte(), rand_byte(), rand_byte(), rand_byte(), live);
  endtask

  task automatic cfg_beat(input logic [CfgIdxW-1:0] idx, input logic [ByteW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  task automatic write_regs(input cfg_regs_t v);
    cfg_beat(CFG_SYNC, v.sync);
    cfg_beat(CFG_VERSION, v.version);
    cfg_beat(CFG_TYPE_INIT, v.type_init);
    cfg_beat(CFG_TYPE_RX, v.type_rx);
    cfg_beat(CFG_TYPE_STATUS, v.type_status);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic settle_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (bytes_pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic send_random_frame();
    int          pick;
    int          plen;
    int          sent_len;
    logic [1:0]  op;
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      op = 2'($urandom_range(0, 3));
      send_item(op, rand_addr(), rand_byte(), rand_byte(), rand_byte(), rand_byte(),
                op != OP_DATA);
    end else if (pick < 30) begin
      send_item(OP_INIT, rand_addr(), rand_byte(), rand_byte(), rand_byte(), rand_byte(),
                1'b1);
    end else if (pick < 48) begin
      send_item(OP_STATUS, rand_addr(), rand_byte(), rand_byte(), rand_byte(), rand_byte(),
                1'b1);
    end else begin
      plen = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
      sent_len = plen;
      if ($urandom_range(0, 9) == 0) begin
        sent_len = $urandom_range(0, plen);
      end
      send_item(OP_RX, rand_addr(), rand_byte(), 8'(plen), rand_byte(), rand_byte(), 1'b1);
      repeat (sent_len) send_payload(1'b1);
      if ($urandom_range(0, 9) == 0) begin
        send_payload(1'b0);
      end
    end
  endtask

  task automatic run_phase(input int send_pct, input int recv_pct, input int n_items,
                           input bit with_hold);
    int first;
    bit held;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    first = live_items;
    held = 1'b0;
    while (live_items - first < n_items) begin
      if (with_hold && !held && live_items - first >= HoldAfter) begin
        hold_req <= 1'b1;
        held = 1'b1;
      end
      send_random_frame();
    end
  endtask

  initial begin : stimulus
    int        plen;
    cfg_regs_t regs_v;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_item(OP_INIT, '0, '0, '0, '0, '0, 1'b1);
    send_item(OP_INIT, '1, '1, '1, '1, '1, 1'b1);
    send_item(OP_STATUS, '1, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1);
    send_item(OP_STATUS, 48'h0123_4567_89AB, 8'h5A, 8'h33, 8'hFF, 8'hC3, 1'b1);
    send_item(OP_RX, 48'hFEDC_BA98_7654, 8'h80, 8'd0, 8'h11, 8'h22, 1'b1);
    send_item(OP_RX, 48'h8000_0000_0001, 8'h7F, 8'd3, 8'h00, 8'h00, 1'b1);
    send_item(OP_DATA, '0, '0, '0, '0, 8'h00, 1'b1);
    send_item(OP_DATA, '0, '0, '0, '0, 8'hFF, 1'b1);
    send_item(OP_DATA, '0, '0, '0, '0, 8'h5A, 1'b1);
    send_item(OP_DATA, '0, '0, '0, '0, 8'hA5, 1'b0);
    send_item(OP_RX, 48'h0000_0000_00FF, 8'h01, 8'd4, 8'h00, 8'h00, 1'b1);
    send_item(OP_DATA, '0, '0, '0, '0, 8'h11, 1'b1);
    send_item(OP_DATA, '0, '0, '0, '0, 8'h22, 1'b1);
    send_item(OP_INIT, 48'hAAAA_5555_AAAA, '0, '0, '0, '0, 1'b1);
    send_item(OP_DATA, '0, '0, '0, '0, 8'h33, 1'b0);
    send_item(OP_RX, 48'h5555_AAAA_5555, 8'hFE, 8'd246, 8'h00, 8'h00, 1'b1);
    send_item(OP_STATUS, 48'h1234_5678_9ABC, 8'h00, 8'h00, 8'h80, 8'h00, 1'b1);
    send_item(OP_RX, 48'h0F0F_0F0F_0F0F, 8'h00, 8'd255, 8'h00, 8'h00, 1'b1);
    send_item(OP_RX, 48'hF0F0_F0F0_F0F0, 8'hFF, 8'd1, 8'h00, 8'h00, 1'b1);
    send_item(OP_DATA, '0, '0, '0, '0, 8'hC3, 1'b1);
    send_item(OP_RX, 48'h7FFF_FFFF_FFFF, 8'hFF, 8'd1, 8'h00, 8'h00, 1'b1);
    send_item(OP_DATA, '0, '0, '0, '0, 8'h80, 1'b1);
    send_item(OP_DATA, '0, '0, '0, '0, 8'h01, 1'b0);
    settle_idle();

    regs_v = '{sync: rand_byte(), version: rand_byte(), type_init: rand_byte(),
               type_rx: rand_byte(), type_status: rand_byte()};
    write_regs(regs_v);
    run_phase(37, 46, 18, 1'b1);
    settle_idle();

    write_regs('0);
    run_phase(46, 37, 10, 1'b0);
    settle_idle();

    write_regs('1);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    plen = $urandom_range(MaxPayload, 255);
    send_item(OP_RX, rand_addr(), rand_byte(), 8'(plen), rand_byte(), rand_byte(), 1'b1);
    repeat (MaxPayload) send_payload(1'b1);
    send_payload(1'b0);
    settle_idle();

    if (fail_count == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
